[design/pvs_pkg.sv]
// Package for the page replacement victim selector.
// Holds the frame table size, field widths, operation and policy codes and the
// transaction payload types. No dependencies.
package pvs_pkg;

    localparam int FRAMES = 16;
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    localparam int FRAME_FIELD_W = 4;
    localparam int PAGE_W = 20;
    localparam int TIME_W = 32;
    localparam int POLICY_W = 2;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [POLICY_W-1:0] POLICY_LRU = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_SECOND_CHANCE = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_CLOCK = 2'd2;

    typedef struct packed {
        logic                     op;
        logic [FRAME_FIELD_W-1:0] frame_index;
        logic [PAGE_W-1:0]        page_number;
        logic [TIME_W-1:0]        access_time;
    } pvs_in_t;

    typedef struct packed {
        logic [FRAME_FIELD_W-1:0] victim_frame;
        logic [PAGE_W-1:0]        evicted_page;
        logic                     evicted_valid;
    } pvs_out_t;

    // Next frame with wrap at the table size
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(FRAMES - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + IDX_W'(1);
        end
        return r;
    endfunction

endpackage

[design/page_replacement_victim_select.sv]
// Page replacement victim selector: frame table, LRU scan and clock / second
// chance hand sweeps under one small sequencer. Depends on pvs_pkg.
//
//  channel   | signals                                   | dir | notes
//  ----------+-------------------------------------------+-----+---------------------------
//  in        | in_valid, in_ready, in_data (pvs_in_t)    | in  | access or select transaction
//  out       | out_valid, out_ready, out_data (pvs_out_t)| out | one per select transaction
//  config    | policy_mode_wr_en, policy_mode_wr_data    | in  | write only, no wait
//
// Steps: an access transaction is taken in the idle state and yields no result. A
// select transaction under LRU reads the table once per frame through the single
// time comparator, settles the last compare, reads the victim's page, then loads
// the output register. Clock and second chance visit k frames with the hand
// (1 to FRAMES + 1 for clock, 1 to FRAMES for second chance), one reference bit
// per cycle, then read the victim's page and load the output.
// Reset clears valid and reference bits, both hands and the policy; the page and
// time memories need no clearing as an invalid frame reads as page 0, time 0.
// A finished result waits in the output register; a new transaction is taken
// meanwhile, and only a second result stalls until the first one has left.
module page_replacement_victim_select (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         policy_mode_wr_en,
    input  logic [pvs_pkg::POLICY_W-1:0] policy_mode_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pvs_pkg::pvs_in_t             in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pvs_pkg::pvs_out_t            out_data
);
    import pvs_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_LRU_SCAN  = 3'd1;
    localparam logic [2:0] ST_LRU_DRAIN = 3'd2;
    localparam logic [2:0] ST_HAND      = 3'd3;
    localparam logic [2:0] ST_LOOKUP    = 3'd4;
    localparam logic [2:0] ST_RESULT    = 3'd5;

    // Frame table payload memories
    logic [PAGE_W-1:0] page_mem [FRAMES];
    logic [TIME_W-1:0] time_mem [FRAMES];

    logic [2:0]          state_reg, state_next;
    logic [POLICY_W-1:0] policy_reg, policy_next;
    logic [FRAMES-1:0]   valid_reg, valid_next;
    logic [FRAMES-1:0]   ref_reg, ref_next;
    logic [IDX_W-1:0]    clock_hand_reg, clock_hand_next;
    logic [IDX_W-1:0]    sc_hand_reg, sc_hand_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic                sc_mode_reg, sc_mode_next;
    logic [IDX_W-1:0]    victim_reg, victim_next;
    logic [TIME_W-1:0]   best_time_reg, best_time_next;
    logic                cmp_en_reg, cmp_en_next;
    logic                out_valid_reg, out_valid_next;
    pvs_out_t            out_data_reg, out_data_next;

    // Registered table read port
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic [PAGE_W-1:0] rd_page_reg;
    logic              rd_vld_reg;

    logic             in_xact;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             idx_ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xact   = in_valid && in_ready;
    assign idx_ok    = (32'(in_data.frame_index) < 32'(FRAMES));
    assign wr_idx    = IDX_W'(in_data.frame_index);
    assign wr_en     = in_xact && (in_data.op == OP_ACCESS) && idx_ok;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        valid_next      = valid_reg;
        ref_next        = ref_reg;
        clock_hand_next = clock_hand_reg;
        sc_hand_next    = sc_hand_reg;
        ptr_next        = ptr_reg;
        start_next      = start_reg;
        sc_mode_next    = sc_mode_reg;
        victim_next     = victim_reg;
        best_time_next  = best_time_reg;
        cmp_en_next     = (state_reg == ST_LRU_SCAN);
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        rd_addr         = victim_reg;

        if (policy_mode_wr_en)
        begin
            policy_next = policy_mode_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Shared time comparator: first frame seeds, strictly smaller wins
        if (cmp_en_reg && ((rd_idx_reg == '0) || (rd_time_reg < best_time_reg)))
        begin
            victim_next    = rd_idx_reg;
            best_time_next = rd_time_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    if (in_data.op == OP_ACCESS)
                    begin
                        if (idx_ok)
                        begin
                            valid_next[wr_idx] = 1'b1;
                            ref_next[wr_idx]   = 1'b1;
                        end
                    end
                    else
                    begin
                        case (policy_reg)
                            POLICY_SECOND_CHANCE:
                            begin
                                ptr_next     = sc_hand_reg;
                                start_next   = sc_hand_reg;
                                sc_mode_next = 1'b1;
                                state_next   = ST_HAND;
                            end
                            POLICY_CLOCK:
                            begin
                                ptr_next     = clock_hand_reg;
                                start_next   = clock_hand_reg;
                                sc_mode_next = 1'b0;
                                state_next   = ST_HAND;
                            end
                            default:
                            begin
                                // LRU, and the unused code behaves the same
                                ptr_next   = '0;
                                state_next = ST_LRU_SCAN;
                            end
                        endcase
                    end
                end
            end
            ST_LRU_SCAN:
            begin
                rd_addr  = ptr_reg;
                ptr_next = next_slot(ptr_reg);
                if (ptr_reg == IDX_W'(FRAMES - 1))
                begin
                    state_next = ST_LRU_DRAIN;
                end
            end
            ST_LRU_DRAIN:
            begin
                state_next = ST_LOOKUP;
            end
            ST_HAND:
            begin
                if (!ref_reg[ptr_reg])
                begin
                    victim_next = ptr_reg;
                    state_next  = ST_LOOKUP;
                    if (sc_mode_reg)
                    begin
                        // second chance steps one extra frame past the victim
                        sc_hand_next = next_slot(next_slot(ptr_reg));
                    end
                    else
                    begin
                        clock_hand_next = next_slot(ptr_reg);
                    end
                end
                else
                begin
                    ref_next[ptr_reg] = 1'b0;
                    if (sc_mode_reg && (next_slot(ptr_reg) == start_reg))
                    begin
                        // full lap with every bit set: the start frame goes
                        victim_next  = start_reg;
                        sc_hand_next = next_slot(start_reg);
                        state_next   = ST_LOOKUP;
                    end
                    else
                    begin
                        ptr_next = next_slot(ptr_reg);
                    end
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.victim_frame  = FRAME_FIELD_W'(victim_reg);
                    out_data_next.evicted_page  = rd_vld_reg ? rd_page_reg : '0;
                    out_data_next.evicted_valid = rd_vld_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            policy_reg     <= POLICY_LRU;
            valid_reg      <= '0;
            ref_reg        <= '0;
            clock_hand_reg <= '0;
            sc_hand_reg    <= '0;
            ptr_reg        <= '0;
            start_reg      <= '0;
            sc_mode_reg    <= 1'b0;
            victim_reg     <= '0;
            cmp_en_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            valid_reg      <= valid_next;
            ref_reg        <= ref_next;
            clock_hand_reg <= clock_hand_next;
            sc_hand_reg    <= sc_hand_next;
            ptr_reg        <= ptr_next;
            start_reg      <= start_next;
            sc_mode_reg    <= sc_mode_next;
            victim_reg     <= victim_next;
            cmp_en_reg     <= cmp_en_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers and the table memories
    always_ff @(posedge clk)
    begin
        best_time_reg <= best_time_next;
        out_data_reg  <= out_data_next;
        if (wr_en)
        begin
            page_mem[wr_idx] <= in_data.page_number;
            time_mem[wr_idx] <= in_data.access_time;
        end
        // an empty frame reads as time zero
        rd_idx_reg  <= rd_addr;
        rd_time_reg <= valid_reg[rd_addr] ? time_mem[rd_addr] : '0;
        rd_page_reg <= page_mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    // The input side is closed whenever the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input ready while sequencer busy");

    // A result appears only out of the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result loaded outside result state");

    // An empty victim reports page zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.evicted_valid) |-> (out_data_reg.evicted_page == '0))
        else $error("empty victim with non-zero page");

    // The hand sweep never sets a reference bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HAND) |=> ((ref_reg & ~$past(ref_reg)) == '0))
        else $error("reference bit set during sweep");

    // Every completed LRU scan moves to the victim lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LRU_DRAIN) |=> (state_reg == ST_LOOKUP))
        else $error("LRU drain did not reach lookup");

endmodule
